// File: hw/rtl/pslw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pslw_pkg;

   // number of pedal sources held, source 0 is the throttle
   localparam int NumSources = 3;
   localparam int SrcSelW    = $clog2(NumSources);

   // field widths
   localparam int ValW     = 16;
   localparam int CfgW     = 15;
   localparam int KindW    = 2;
   localparam int SrcW     = 3;
   localparam int StatusW  = 2;
   localparam int CsrIndexW = 2;

   // item kinds
   localparam logic [KindW-1:0] KindUpdate    = 2'd0;
   localparam logic [KindW-1:0] KindWatchdog  = 2'd1;
   localparam logic [KindW-1:0] KindBroadcast = 2'd2;

   // result status codes
   localparam logic [StatusW-1:0] StatusOk    = 2'd0;
   localparam logic [StatusW-1:0] StatusRange = 2'd1;
   localparam logic [StatusW-1:0] StatusFault = 2'd2;

   // register indexes
   localparam logic [CsrIndexW-1:0] CsrJumpThreshold = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrSlewStep      = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrOutputLimit   = 2'd2;

   // register reset values
   localparam logic [CfgW-1:0] JumpThresholdReset = 15'd1000;
   localparam logic [CfgW-1:0] SlewStepReset      = 15'd100;
   localparam logic [CfgW-1:0] OutputLimitReset   = 15'd4096;

   localparam logic [NumSources-1:0] AllFresh = '1;

   typedef struct packed {
      logic [CfgW-1:0] jump_threshold;
      logic [CfgW-1:0] slew_step;
      logic [CfgW-1:0] output_limit;
   } cfg_type;

   typedef struct packed {
      logic [KindW-1:0]       kind;
      logic [SrcW-1:0]        source_index;
      logic signed [ValW-1:0] sample_value;
   } item_type;

   typedef struct packed {
      logic [StatusW-1:0]     status;
      logic                   frame_valid;
      logic                   update_request;
      logic signed [ValW-1:0] throttle_out;
      logic signed [ValW-1:0] throttle_state_out;
      logic signed [ValW-1:0] brake_out;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/pslw_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module pslw_csr
   import pslw_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [CsrIndexW-1:0] wr_index,
   input  wire logic [CfgW-1:0]      wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CsrJumpThreshold: cfg_in.jump_threshold = wr_data;
            CsrSlewStep:      cfg_in.slew_step      = wr_data;
            CsrOutputLimit:   cfg_in.output_limit   = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_threshold <= JumpThresholdReset;
         cfg_ff.slew_step      <= SlewStepReset;
         cfg_ff.output_limit   <= OutputLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pslw_slew.sv
`timescale 1ns / 1ps
`default_nettype none

module pslw_slew
   import pslw_pkg::*;
(
   input  wire logic signed [ValW-1:0] prev,
   input  wire logic signed [ValW-1:0] next,
   input  wire cfg_type                cfg,
   output logic signed [ValW-1:0]      limited
);

   // 18 bits hold every difference, its negation and prev plus or minus a step
   logic signed [ValW+1:0] prev_x;
   logic signed [ValW+1:0] next_x;
   logic signed [ValW+1:0] diff;
   logic signed [ValW+1:0] diff_mag;
   logic signed [ValW+1:0] torque;
   logic signed [ValW+1:0] thresh;
   logic signed [ValW+1:0] step;
   logic signed [ValW+1:0] lim;
   logic signed [ValW+1:0] moved;
   logic signed [ValW+1:0] clamped;
   logic                   next_neg;
   logic                   prev_neg;
   logic                   jump;

   assign prev_x   = {{2{prev[ValW-1]}}, prev};
   assign next_x   = {{2{next[ValW-1]}}, next};
   assign diff     = next_x - prev_x;
   assign diff_mag = diff[ValW+1] ? -diff : diff;
   assign next_neg = next[ValW-1];
   assign prev_neg = prev[ValW-1];
   assign torque   = next_neg ? -diff : diff;
   assign thresh   = {3'b000, cfg.jump_threshold};
   assign step     = {3'b000, cfg.slew_step};
   assign lim      = {3'b000, cfg.output_limit};

   // sign flip compares the magnitude, same sign compares the torque increase
   assign jump = (next_neg != prev_neg) ? (diff_mag > thresh) : (torque > thresh);

   // one step toward the new value's sign, then clamp to the limit
   assign moved = next_neg ? (prev_x - step) : (prev_x + step);

   always_comb begin
      clamped = moved;
      if (moved > lim) begin
         clamped = lim;
      end
      if (moved < -lim) begin
         clamped = -lim;
      end
   end

   // zero always passes unlimited
   assign limited = (next == '0 || !jump) ? next : clamped[ValW-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/pslw_state.sv
`timescale 1ns / 1ps
`default_nettype none

module pslw_state
   import pslw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   logic signed [ValW-1:0] values_ff [NumSources];
   logic signed [ValW-1:0] values_in [NumSources];
   logic [NumSources-1:0]  fresh_ff;
   logic [NumSources-1:0]  fresh_in;
   logic signed [ValW-1:0] throttle_limited;
   logic [SrcSelW-1:0]     sel;
   logic                   in_range;

   pslw_slew u_slew (
      .prev    (values_ff[0]),
      .next    (item.sample_value),
      .cfg     (cfg),
      .limited (throttle_limited)
   );

   assign sel      = item.source_index[SrcSelW-1:0];
   assign in_range = ({1'b0, item.source_index} < (SrcW + 1)'(NumSources));

   // read-modify-write of the source table for the word in the input stage
   always_comb begin
      values_in = values_ff;
      fresh_in  = fresh_ff;
      result    = '0;
      case (item.kind)
         KindUpdate: begin
            if (!in_range) begin
               result.status = StatusRange;
            end else begin
               values_in[sel] = (sel == '0) ? throttle_limited : item.sample_value;
               fresh_in[sel]  = 1'b1;
            end
         end
         KindWatchdog: begin
            if (fresh_ff != AllFresh) begin
               for (int i = 0; i < NumSources; i++) begin
                  values_in[i] = '0;
               end
               result.status = StatusFault;
            end
            fresh_in = '0;
         end
         KindBroadcast: begin
            result.frame_valid        = 1'b1;
            result.update_request     = 1'b1;
            result.throttle_out       = values_ff[0];
            result.throttle_state_out = values_ff[1];
            result.brake_out          = values_ff[2];
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSources; i++) begin
            values_ff[i] <= '0;
         end
         fresh_ff <= '0;
      end else if (fire) begin
         values_ff <= values_in;
         fresh_ff  <= fresh_in;
      end
   end

`ifndef SYNTHESIS
   // watchdog tick always leaves every source stale
   a_watchdog_clears_fresh: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == KindWatchdog |=> fresh_ff == '0)
      else $error("fresh bits not cleared by watchdog tick");

   // a fault zeroes the throttle value
   a_fault_clears_values: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == StatusFault |=> values_ff[0] == '0)
      else $error("throttle value survived a watchdog fault");

   // an out of range update leaves the fresh bits alone
   a_range_no_change: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == StatusRange |=> $stable(fresh_ff))
      else $error("out of range update changed fresh bits");

   // a valid update marks its source fresh
   a_update_sets_fresh: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == KindUpdate && in_range |=> fresh_ff[$past(sel)])
      else $error("update did not set its fresh bit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pedal_slew_limit_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none

// Pedal slew limiter and watchdog. Every accepted word yields exactly one
// result word, and a new word can be taken every cycle while the result
// side is not stalled: the word is registered on entry, a single pass of
// logic reads and updates the source table and the fresh bits, and the
// answer lands in an output register, so one more word can enter while a
// finished result waits. Words are handled strictly in order, each seeing
// the table as left by the one before. Registers are written through the
// csr port, which is always ready, and should only be changed while no
// word is in flight.
module pedal_slew_limit_watchdog
   import pslw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [KindW-1:0]       req_kind,
   input  wire logic [SrcW-1:0]        req_source_index,
   input  wire logic signed [ValW-1:0] req_sample_value,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [StatusW-1:0]          rsp_status,
   output logic                        rsp_frame_valid,
   output logic                        rsp_update_request,
   output logic signed [ValW-1:0]      rsp_throttle_out,
   output logic signed [ValW-1:0]      rsp_throttle_state_out,
   output logic signed [ValW-1:0]      rsp_brake_out,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIndexW-1:0]   csr_index,
   input  wire logic [CfgW-1:0]        csr_data
);

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_v_ff;
   logic       item_v_in;
   result_type result;
   result_type out_ff;
   result_type out_in;
   logic       out_v_ff;
   logic       out_v_in;
   logic       out_free;
   logic       fire;
   logic       req_take;

   assign csr_ready = 1'b1;

   pslw_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pslw_state u_state (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // stage handshake
   assign out_free  = !out_v_ff || !rsp_stall;
   assign fire      = item_v_ff && out_free;
   assign req_stall = item_v_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input stage
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.kind         = req_kind;
         item_in.source_index = req_source_index;
         item_in.sample_value = req_sample_value;
      end
   end
   assign item_v_in = req_take || (item_v_ff && !fire);

   // result stage
   assign out_in   = fire ? result : out_ff;
   assign out_v_in = fire || (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         item_v_ff <= item_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid              = out_v_ff;
   assign rsp_status             = out_ff.status;
   assign rsp_frame_valid        = out_ff.frame_valid;
   assign rsp_update_request     = out_ff.update_request;
   assign rsp_throttle_out       = out_ff.throttle_out;
   assign rsp_throttle_state_out = out_ff.throttle_state_out;
   assign rsp_brake_out          = out_ff.brake_out;

`ifndef SYNTHESIS
   // a full input stage behind a blocked result must push back
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      item_v_ff && out_v_ff && rsp_stall |-> req_stall)
      else $error("input taken while pipeline blocked");

   // a processed word always reaches the result register
   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_v_ff)
      else $error("processed word lost");

   // broadcast frames carry no error status
   a_frame_status: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.frame_valid |-> out_ff.status == StatusOk && out_ff.update_request)
      else $error("bad broadcast result");
`endif

endmodule

`default_nettype wire
